// ----- rtl/i2cram_pkg.sv -----
// Shared types and constants for the I2C register access master.
// No dependencies; used by i2cram_core and the top level.
package i2cram_pkg;

  localparam int ByteW = 8;
  localparam int OpW   = 2;
  localparam int CntW  = 4;

  // command codes on the op field
  localparam logic [OpW-1:0] OP_READ  = 2'd0;
  localparam logic [OpW-1:0] OP_WRITE = 2'd1;
  localparam logic [OpW-1:0] OP_TICK  = 2'd2;

  // which byte is on the bus
  localparam logic [1:0] STAGE_DEV_W = 2'd0;
  localparam logic [1:0] STAGE_REG   = 2'd1;
  localparam logic [1:0] STAGE_DATA  = 2'd2;
  localparam logic [1:0] STAGE_DEV_R = 2'd3;

  localparam logic [CntW-1:0]  BitsPerByte = 4'd8;
  localparam logic [ByteW-1:0] DevAddrRst  = 8'd162;
  localparam logic [ByteW-1:0] ReadBit     = 8'h01;

  typedef struct packed {
    logic             scl_level;
    logic             sda_level;
    logic             busy_res;
    logic             done_res;
    logic             ack_failed;
    logic [ByteW-1:0] read_result;
  } res_t;

endpackage

// ----- rtl/i2cram_core.sv -----
// Transaction state and per-request next-state logic of the I2C master.
// Depends on i2cram_pkg; instantiated by i2c_register_access_master_unit.
module i2cram_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [i2cram_pkg::ByteW-1:0]  cfg_wdata,
  input  logic                          accept,
  input  logic [i2cram_pkg::OpW-1:0]    op,
  input  logic [i2cram_pkg::ByteW-1:0]  reg_addr,
  input  logic [i2cram_pkg::ByteW-1:0]  write_data,
  input  logic                          sda_in,
  output i2cram_pkg::res_t              res_nxt
);

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_ST_SDA_HI = 5'd1,
    PH_ST_SCL_HI = 5'd2,
    PH_ST_SDA_LO = 5'd3,
    PH_ST_SCL_LO = 5'd4,
    PH_ST_SDA_RL = 5'd5,
    PH_WB_DATA   = 5'd6,
    PH_WB_SCL_HI = 5'd7,
    PH_WB_SCL_LO = 5'd8,
    PH_WA_REL    = 5'd9,
    PH_WA_SCL_HI = 5'd10,
    PH_WA_SCL_LO = 5'd11,
    PH_RB_SCL_HI = 5'd12,
    PH_RB_SCL_LO = 5'd13,
    PH_RN_SDA_HI = 5'd14,
    PH_RN_SCL_HI = 5'd15,
    PH_RN_SCL_LO = 5'd16,
    PH_SP_SDA_LO = 5'd17,
    PH_SP_SCL_HI = 5'd18,
    PH_SP_SDA_HI = 5'd19
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [i2cram_pkg::CntW-1:0]   bit_count_r, bit_count_nxt;
  logic [i2cram_pkg::ByteW-1:0]  shift_r, shift_nxt;
  logic [i2cram_pkg::ByteW-1:0]  lat_reg_r, lat_reg_nxt;
  logic [i2cram_pkg::ByteW-1:0]  lat_data_r, lat_data_nxt;
  logic                          is_write_r, is_write_nxt;
  logic                          failed_r, failed_nxt;
  logic                          scl_r, scl_nxt;
  logic                          sda_r, sda_nxt;
  logic [i2cram_pkg::ByteW-1:0]  read_byte_r, read_byte_nxt;
  logic [1:0]                    stage_r, stage_nxt;
  logic [i2cram_pkg::ByteW-1:0]  dev_addr_r;
  logic [i2cram_pkg::CntW-1:0]   bc_inc;
  logic                          done;

  assign bc_inc = bit_count_r + 4'd1;

  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    lat_reg_nxt   = lat_reg_r;
    lat_data_nxt  = lat_data_r;
    is_write_nxt  = is_write_r;
    failed_nxt    = failed_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    read_byte_nxt = read_byte_r;
    stage_nxt     = stage_r;
    done          = 1'b0;
    if (accept) begin
      if (phase_r == PH_IDLE) begin
        if (op == i2cram_pkg::OP_READ || op == i2cram_pkg::OP_WRITE) begin
          lat_reg_nxt   = reg_addr;
          lat_data_nxt  = write_data;
          is_write_nxt  = (op == i2cram_pkg::OP_WRITE);
          failed_nxt    = 1'b0;
          stage_nxt     = i2cram_pkg::STAGE_DEV_W;
          shift_nxt     = dev_addr_r;
          bit_count_nxt = '0;
          phase_nxt     = PH_ST_SDA_HI;
        end
      end else if (op == i2cram_pkg::OP_TICK) begin
        case (phase_r)
          PH_ST_SDA_HI: begin sda_nxt = 1'b1; phase_nxt = PH_ST_SCL_HI; end
          PH_ST_SCL_HI: begin scl_nxt = 1'b1; phase_nxt = PH_ST_SDA_LO; end
          PH_ST_SDA_LO: begin sda_nxt = 1'b0; phase_nxt = PH_ST_SCL_LO; end
          PH_ST_SCL_LO: begin scl_nxt = 1'b0; phase_nxt = PH_ST_SDA_RL; end
          PH_ST_SDA_RL: begin sda_nxt = 1'b1; phase_nxt = PH_WB_DATA; end
          PH_WB_DATA: begin
            sda_nxt   = shift_r[i2cram_pkg::ByteW-1];
            phase_nxt = PH_WB_SCL_HI;
          end
          PH_WB_SCL_HI: begin scl_nxt = 1'b1; phase_nxt = PH_WB_SCL_LO; end
          PH_WB_SCL_LO: begin
            scl_nxt   = 1'b0;
            shift_nxt = {shift_r[i2cram_pkg::ByteW-2:0], 1'b0};
            if (bc_inc >= i2cram_pkg::BitsPerByte) begin
              bit_count_nxt = '0;
              phase_nxt     = PH_WA_REL;
            end else begin
              bit_count_nxt = bc_inc;
              phase_nxt     = PH_WB_DATA;
            end
          end
          PH_WA_REL: begin sda_nxt = 1'b1; phase_nxt = PH_WA_SCL_HI; end
          PH_WA_SCL_HI: begin
            scl_nxt = 1'b1;
            if (sda_in) begin
              failed_nxt = 1'b1;
            end
            phase_nxt = PH_WA_SCL_LO;
          end
          PH_WA_SCL_LO: begin
            scl_nxt = 1'b0;
            if (failed_r) begin
              phase_nxt = PH_SP_SDA_LO;
            end else begin
              case (stage_r)
                i2cram_pkg::STAGE_DEV_W: begin
                  stage_nxt     = i2cram_pkg::STAGE_REG;
                  shift_nxt     = lat_reg_r;
                  bit_count_nxt = '0;
                  phase_nxt     = PH_WB_DATA;
                end
                i2cram_pkg::STAGE_REG: begin
                  bit_count_nxt = '0;
                  if (is_write_r) begin
                    stage_nxt = i2cram_pkg::STAGE_DATA;
                    shift_nxt = lat_data_r;
                    phase_nxt = PH_WB_DATA;
                  end else begin
                    // repeated start, then the device address plus the read bit
                    stage_nxt = i2cram_pkg::STAGE_DEV_R;
                    shift_nxt = dev_addr_r + i2cram_pkg::ReadBit;
                    phase_nxt = PH_ST_SDA_HI;
                  end
                end
                i2cram_pkg::STAGE_DEV_R: begin
                  shift_nxt     = '0;
                  bit_count_nxt = '0;
                  phase_nxt     = PH_RB_SCL_HI;
                end
                default: phase_nxt = PH_SP_SDA_LO;
              endcase
            end
          end
          PH_RB_SCL_HI: begin
            scl_nxt   = 1'b1;
            shift_nxt = {shift_r[i2cram_pkg::ByteW-2:0], sda_in};
            phase_nxt = PH_RB_SCL_LO;
          end
          PH_RB_SCL_LO: begin
            scl_nxt = 1'b0;
            if (bc_inc >= i2cram_pkg::BitsPerByte) begin
              bit_count_nxt = '0;
              phase_nxt     = PH_RN_SDA_HI;
            end else begin
              bit_count_nxt = bc_inc;
              phase_nxt     = PH_RB_SCL_HI;
            end
          end
          PH_RN_SDA_HI: begin sda_nxt = 1'b1; phase_nxt = PH_RN_SCL_HI; end
          PH_RN_SCL_HI: begin scl_nxt = 1'b1; phase_nxt = PH_RN_SCL_LO; end
          PH_RN_SCL_LO: begin scl_nxt = 1'b0; phase_nxt = PH_SP_SDA_LO; end
          PH_SP_SDA_LO: begin sda_nxt = 1'b0; phase_nxt = PH_SP_SCL_HI; end
          PH_SP_SCL_HI: begin scl_nxt = 1'b1; phase_nxt = PH_SP_SDA_HI; end
          PH_SP_SDA_HI: begin
            sda_nxt = 1'b1;
            if (!is_write_r) begin
              read_byte_nxt = failed_r ? '0 : shift_r;
            end
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    res_nxt.scl_level   = scl_nxt;
    res_nxt.sda_level   = sda_nxt;
    res_nxt.busy_res    = (phase_nxt != PH_IDLE);
    res_nxt.done_res    = done;
    res_nxt.ack_failed  = failed_nxt;
    res_nxt.read_result = read_byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_count_r <= '0;
      shift_r     <= '0;
      lat_reg_r   <= '0;
      lat_data_r  <= '0;
      is_write_r  <= 1'b0;
      failed_r    <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      read_byte_r <= '0;
      stage_r     <= i2cram_pkg::STAGE_DEV_W;
      dev_addr_r  <= i2cram_pkg::DevAddrRst;
    end else begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      lat_reg_r   <= lat_reg_nxt;
      lat_data_r  <= lat_data_nxt;
      is_write_r  <= is_write_nxt;
      failed_r    <= failed_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      read_byte_r <= read_byte_nxt;
      stage_r     <= stage_nxt;
      if (cfg_we) begin
        dev_addr_r <= cfg_wdata;
      end
    end
  end

  // stop completion always returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_nxt.done_res |=> phase_r == PH_IDLE)
    else $error("done without returning to idle");

  // a missed acknowledge goes straight to the stop sequence
  a_fail_stop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && op == i2cram_pkg::OP_TICK && phase_r == PH_WA_SCL_LO && failed_r
    |=> phase_r == PH_SP_SDA_LO)
    else $error("missed ack did not lead to stop");

  // bit counter stays inside one byte while shifting
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WB_DATA || phase_r == PH_RB_SCL_HI)
    |-> bit_count_r < i2cram_pkg::BitsPerByte)
    else $error("bit counter out of range");

  // state only moves on an accepted request
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(phase_r) && $stable(shift_r) && $stable(read_byte_r))
    else $error("state changed without a request");

endmodule

// ----- rtl/i2c_register_access_master_unit.sv -----
// I2C register read/write master: one request per cycle while in_ready is high.
// A result is valid the cycle after its request is accepted.
// The result register is the only stage, and in_ready stays high while
// out_ready takes the held result.
// Reset (rst_n, synchronous, active low): idle, both lines released, address 162.
// Depends on i2cram_pkg and i2cram_core.
module i2c_register_access_master_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [i2cram_pkg::ByteW-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [i2cram_pkg::OpW-1:0]    in_op,
  input  logic [i2cram_pkg::ByteW-1:0]  in_reg_addr,
  input  logic [i2cram_pkg::ByteW-1:0]  in_write_data,
  input  logic                          in_sda_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_scl_level,
  output logic                          out_sda_level,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic                          out_ack_failed,
  output logic [i2cram_pkg::ByteW-1:0]  out_read_result
);

  logic             accept;
  logic             out_valid_r;
  i2cram_pkg::res_t res_nxt;
  i2cram_pkg::res_t res_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  i2cram_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .op         (in_op),
    .reg_addr   (in_reg_addr),
    .write_data (in_write_data),
    .sda_in     (in_sda_in),
    .res_nxt    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl_level   = res_r.scl_level;
  assign out_sda_level   = res_r.sda_level;
  assign out_busy_res    = res_r.busy_res;
  assign out_done_res    = res_r.done_res;
  assign out_ack_failed  = res_r.ack_failed;
  assign out_read_result = res_r.read_result;

endmodule

// ----- verif/i2c_register_access_master_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench for i2c_register_access_master_unit: I2C register read/write transactions
// driven as bus-phase tick requests, checked against a cycle-free bus phase predictor.
// Depends on i2cram_pkg and the RTL of i2c_register_access_master_unit.
module i2c_register_access_master_unit_tb;

  // op code with no meaning; the block must ignore it
  localparam logic [i2cram_pkg::OpW-1:0] OP_SPARE = 2'd3;

  typedef enum logic [4:0] {
    B_IDLE, B_S_SDA1, B_S_SCL1, B_S_SDA0, B_S_SCL0, B_S_REL,
    B_TX_BIT, B_TX_SCL1, B_TX_SCL0, B_ACK_REL, B_ACK_SCL1, B_ACK_SCL0,
    B_RX_SCL1, B_RX_SCL0, B_NK_SDA1, B_NK_SCL1, B_NK_SCL0,
    B_P_SDA0, B_P_SCL1, B_P_SDA1
  } bus_phase_t;

  typedef struct {
    logic [i2cram_pkg::OpW-1:0]   op;
    logic [i2cram_pkg::ByteW-1:0] reg_addr;
    logic [i2cram_pkg::ByteW-1:0] wdata;
    logic                         sda;
  } bus_req_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [i2cram_pkg::ByteW-1:0] cfg_wdata;
  logic                         in_valid;
  logic                         in_ready;
  logic [i2cram_pkg::OpW-1:0]   in_op;
  logic [i2cram_pkg::ByteW-1:0] in_reg_addr;
  logic [i2cram_pkg::ByteW-1:0] in_write_data;
  logic                         in_sda_in;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_scl_level;
  logic                         out_sda_level;
  logic                         out_busy_res;
  logic                         out_done_res;
  logic                         out_ack_failed;
  logic [i2cram_pkg::ByteW-1:0] out_read_result;

  i2c_register_access_master_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_reg_addr    (in_reg_addr),
    .in_write_data  (in_write_data),
    .in_sda_in      (in_sda_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_scl_level  (out_scl_level),
    .out_sda_level  (out_sda_level),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_ack_failed (out_ack_failed),
    .out_read_result(out_read_result)
  );

  bus_req_t         pending_reqs[$];
  i2cram_pkg::res_t bus_expect[$];
  int               errors;
  int               took_count;
  bit               in_took;
  bit               calm;
  int               in_gap;
  int               out_gap;
  int               hold_left;
  bit               hold_used;
  int               junk_pct;
  bit               junk_cmds;

  // predicted block state
  bus_phase_t                   m_phase;
  logic [i2cram_pkg::CntW-1:0]  m_bits;
  logic [i2cram_pkg::ByteW-1:0] m_shift;
  logic [i2cram_pkg::ByteW-1:0] m_reg;
  logic [i2cram_pkg::ByteW-1:0] m_data;
  logic                         m_is_wr;
  logic                         m_fail;
  logic                         m_scl;
  logic                         m_sda;
  logic [i2cram_pkg::ByteW-1:0] m_rd_byte;
  logic [1:0]                   m_stage;
  logic [i2cram_pkg::ByteW-1:0] m_dev_addr;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_model();
    m_phase    = B_IDLE;
    m_bits     = '0;
    m_shift    = '0;
    m_reg      = '0;
    m_data     = '0;
    m_is_wr    = 1'b0;
    m_fail     = 1'b0;
    m_scl      = 1'b1;
    m_sda      = 1'b1;
    m_rd_byte  = '0;
    m_stage    = i2cram_pkg::STAGE_DEV_W;
    m_dev_addr = i2cram_pkg::DevAddrRst;
  endfunction

  function automatic void load_shift(logic [1:0] stage,
                                     logic [i2cram_pkg::ByteW-1:0] value);
    m_stage = stage;
    m_shift = value;
    m_bits  = '0;
  endfunction

  function automatic i2cram_pkg::res_t advance_bus(bus_req_t r);
    i2cram_pkg::res_t res;
    logic fin;
    fin = 1'b0;
    if (m_phase == B_IDLE) begin
      if (r.op == i2cram_pkg::OP_READ || r.op == i2cram_pkg::OP_WRITE) begin
        m_reg   = r.reg_addr;
        m_data  = r.wdata;
        m_is_wr = (r.op == i2cram_pkg::OP_WRITE);
        m_fail  = 1'b0;
        load_shift(i2cram_pkg::STAGE_DEV_W, m_dev_addr);
        m_phase = B_S_SDA1;
      end
    end else if (r.op == i2cram_pkg::OP_TICK) begin
      case (m_phase)
        B_S_SDA1: begin m_sda = 1'b1; m_phase = B_S_SCL1; end
        B_S_SCL1: begin m_scl = 1'b1; m_phase = B_S_SDA0; end
        B_S_SDA0: begin m_sda = 1'b0; m_phase = B_S_SCL0; end
        B_S_SCL0: begin m_scl = 1'b0; m_phase = B_S_REL; end
        B_S_REL: begin m_sda = 1'b1; m_phase = B_TX_BIT; end
        B_TX_BIT: begin
          m_sda   = m_shift[i2cram_pkg::ByteW-1];
          m_phase = B_TX_SCL1;
        end
        B_TX_SCL1: begin m_scl = 1'b1; m_phase = B_TX_SCL0; end
        B_TX_SCL0: begin
          m_scl   = 1'b0;
          m_shift = m_shift << 1;
          m_bits  = m_bits + 1'b1;
          if (m_bits >= i2cram_pkg::BitsPerByte) begin
            m_bits  = '0;
            m_phase = B_ACK_REL;
          end else begin
            m_phase = B_TX_BIT;
          end
        end
        B_ACK_REL: begin m_sda = 1'b1; m_phase = B_ACK_SCL1; end
        B_ACK_SCL1: begin
          m_scl = 1'b1;
          if (r.sda) m_fail = 1'b1;
          m_phase = B_ACK_SCL0;
        end
        B_ACK_SCL0: begin
          m_scl = 1'b0;
          if (m_fail) begin
            m_phase = B_P_SDA0;
          end else begin
            case (m_stage)
              i2cram_pkg::STAGE_DEV_W: begin
                load_shift(i2cram_pkg::STAGE_REG, m_reg);
                m_phase = B_TX_BIT;
              end
              i2cram_pkg::STAGE_REG: begin
                if (m_is_wr) begin
                  load_shift(i2cram_pkg::STAGE_DATA, m_data);
                  m_phase = B_TX_BIT;
                end else begin
                  // repeated start, then the read address
                  load_shift(i2cram_pkg::STAGE_DEV_R, m_dev_addr + i2cram_pkg::ReadBit);
                  m_phase = B_S_SDA1;
                end
              end
              i2cram_pkg::STAGE_DEV_R: begin
                load_shift(i2cram_pkg::STAGE_DEV_R, '0);
                m_phase = B_RX_SCL1;
              end
              default: m_phase = B_P_SDA0;
            endcase
          end
        end
        B_RX_SCL1: begin
          m_scl   = 1'b1;
          m_shift = {m_shift[i2cram_pkg::ByteW-2:0], r.sda};
          m_phase = B_RX_SCL0;
        end
        B_RX_SCL0: begin
          m_scl  = 1'b0;
          m_bits = m_bits + 1'b1;
          if (m_bits >= i2cram_pkg::BitsPerByte) begin
            m_bits  = '0;
            m_phase = B_NK_SDA1;
          end else begin
            m_phase = B_RX_SCL1;
          end
        end
        B_NK_SDA1: begin m_sda = 1'b1; m_phase = B_NK_SCL1; end
        B_NK_SCL1: begin m_scl = 1'b1; m_phase = B_NK_SCL0; end
        B_NK_SCL0: begin m_scl = 1'b0; m_phase = B_P_SDA0; end
        B_P_SDA0: begin m_sda = 1'b0; m_phase = B_P_SCL1; end
        B_P_SCL1: begin m_scl = 1'b1; m_phase = B_P_SDA1; end
        B_P_SDA1: begin
          m_sda = 1'b1;
          if (!m_is_wr) m_rd_byte = m_fail ? '0 : m_shift;
          m_phase = B_IDLE;
          fin     = 1'b1;
        end
        default: m_phase = B_IDLE;
      endcase
    end
    res.scl_level   = m_scl;
    res.sda_level   = m_sda;
    res.busy_res    = (m_phase != B_IDLE);
    res.done_res    = fin;
    res.ack_failed  = m_fail;
    res.read_result = m_rd_byte;
    return res;
  endfunction

  // ---------------- request generation ----------------

  function automatic void push_req(logic [i2cram_pkg::OpW-1:0] op,
                                   logic [i2cram_pkg::ByteW-1:0] ra,
                                   logic [i2cram_pkg::ByteW-1:0] wd, logic sda);
    bus_req_t r;
    r.op       = op;
    r.reg_addr = ra;
    r.wdata    = wd;
    r.sda      = sda;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [i2cram_pkg::ByteW-1:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // one bus tick; sometimes preceded by a request the busy block must ignore
  function automatic void push_tick(logic sda);
    if ($urandom_range(0, 99) < junk_pct) begin
      if (junk_cmds && rnd_bit())
        push_req(rnd_bit() ? i2cram_pkg::OP_WRITE : i2cram_pkg::OP_READ, rnd_byte(),
                 rnd_byte(), rnd_bit());
      else
        push_req(OP_SPARE, rnd_byte(), rnd_byte(), rnd_bit());
    end
    push_req(i2cram_pkg::OP_TICK, rnd_byte(), rnd_byte(), sda);
  endfunction

  function automatic void bus_start();
    repeat (5) push_tick(rnd_bit());
  endfunction

  function automatic void bus_stop();
    repeat (3) push_tick(rnd_bit());
  endfunction

  // eight bits out plus the acknowledge clock; nack = 1 leaves the ack missing
  function automatic void send_byte(logic nack);
    repeat (24) push_tick(rnd_bit());
    push_tick(rnd_bit());
    push_tick(nack);
    push_tick(rnd_bit());
  endfunction

  function automatic void recv_byte(logic [i2cram_pkg::ByteW-1:0] value);
    for (int i = i2cram_pkg::ByteW - 1; i >= 0; i--) begin
      push_tick(value[i]);
      push_tick(rnd_bit());
    end
    repeat (3) push_tick(rnd_bit());
  endfunction

  // fail_at names the byte (0 = device, 1 = register, 2 = data/read address)
  // whose ack goes missing; 3 means all acks arrive
  function automatic void i2c_transfer(logic wr, logic [i2cram_pkg::ByteW-1:0] ra,
                                       logic [i2cram_pkg::ByteW-1:0] wd,
                                       logic [i2cram_pkg::ByteW-1:0] rd, int fail_at);
    push_req(wr ? i2cram_pkg::OP_WRITE : i2cram_pkg::OP_READ, ra, wd, rnd_bit());
    bus_start();
    send_byte(fail_at == 0);
    if (fail_at == 0) begin
      bus_stop();
      return;
    end
    send_byte(fail_at == 1);
    if (fail_at == 1 || wr) begin
      if (wr && fail_at != 1) send_byte(fail_at == 2);
      bus_stop();
      return;
    end
    bus_start();
    send_byte(fail_at == 2);
    if (fail_at != 2) recv_byte(rd);
    bus_stop();
  endfunction

  function automatic void random_transfer();
    int fail_at;
    fail_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 2)) : 3;
    i2c_transfer(rnd_bit(), rnd_byte(), rnd_byte(), rnd_byte(), fail_at);
  endfunction

  // command followed by ticks with random data, padded until the bus is surely idle
  function automatic void garbled_transfer();
    junk_cmds = 1'b0;
    push_req(rnd_bit() ? i2cram_pkg::OP_WRITE : i2cram_pkg::OP_READ, rnd_byte(),
             rnd_byte(), rnd_bit());
    repeat (120) push_tick(rnd_bit());
    junk_cmds = 1'b1;
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || bus_expect.size() != 0 || in_valid)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_dev_addr(input logic [i2cram_pkg::ByteW-1:0] value);
    @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------- driver, receiver, monitor ----------------

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        bus_req_t r;
        r = pending_reqs.pop_front();
        in_op         <= r.op;
        in_reg_addr   <= r.reg_addr;
        in_write_data <= r.wdata;
        in_sda_in     <= r.sda;
        in_valid      <= 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) in_gap = $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    // one long hold-off so the block backs up and drops in_ready
    if (!hold_used && took_count >= 400) begin
      hold_used = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 15) == 0) out_gap = $urandom_range(1, 13);
    end
  end

  always @(posedge clk) begin
    i2cram_pkg::res_t got;
    i2cram_pkg::res_t want;
    bus_req_t r;
    in_took = 1'b0;
    if (!rst_n) begin
      clear_model();
    end else begin
      if (in_valid && in_ready) begin
        in_took       = 1'b1;
        took_count++;
        r.op       = in_op;
        r.reg_addr = in_reg_addr;
        r.wdata    = in_write_data;
        r.sda      = in_sda_in;
        bus_expect.push_back(advance_bus(r));
      end
      // a register write applies to requests after this edge
      if (cfg_we) m_dev_addr = cfg_wdata;
      if (out_valid && out_ready) begin
        got.scl_level   = out_scl_level;
        got.sda_level   = out_sda_level;
        got.busy_res    = out_busy_res;
        got.done_res    = out_done_res;
        got.ack_failed  = out_ack_failed;
        got.read_result = out_read_result;
        if (bus_expect.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending: scl=%b sda=%b busy=%b done=%b",
                   $realtime, got.scl_level, got.sda_level, got.busy_res, got.done_res);
        end else begin
          want = bus_expect.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected scl=%b sda=%b busy=%b done=%b fail=%b rd=%02h",
                     $realtime, want.scl_level, want.sda_level, want.busy_res,
                     want.done_res, want.ack_failed, want.read_result);
            $display("%0t:          actual scl=%b sda=%b busy=%b done=%b fail=%b rd=%02h",
                     $realtime, got.scl_level, got.sda_level, got.busy_res,
                     got.done_res, got.ack_failed, got.read_result);
          end
        end
      end
    end
  end

  // ---------------- stimulus ----------------

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_op         = i2cram_pkg::OP_TICK;
    in_reg_addr   = '0;
    in_write_data = '0;
    in_sda_in     = 1'b0;
    out_ready     = 1'b0;
    errors        = 0;
    took_count    = 0;
    in_took       = 1'b0;
    calm          = 1'b0;
    in_gap        = 0;
    out_gap       = 0;
    hold_left     = 0;
    hold_used     = 1'b0;
    junk_pct      = 10;
    junk_cmds     = 1'b1;
    clear_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle: ticks and the spare op code do nothing
    push_req(i2cram_pkg::OP_TICK, 8'hFF, 8'hFF, 1'b1);
    push_req(OP_SPARE, 8'h00, 8'h00, 1'b0);
    push_req(OP_SPARE, 8'hFF, 8'hFF, 1'b1);
    push_req(i2cram_pkg::OP_TICK, 8'h00, 8'h00, 1'b0);
    // reset device address, field extremes, every missing-ack point
    i2c_transfer(1'b1, 8'hFF, 8'h00, 8'h00, 3);
    i2c_transfer(1'b0, 8'h00, 8'hFF, 8'hFF, 3);
    i2c_transfer(1'b1, 8'h00, 8'hFF, 8'h00, 3);
    i2c_transfer(1'b0, 8'hFF, 8'h00, 8'h00, 3);
    i2c_transfer(1'b0, 8'h3C, 8'h11, 8'h96, 0);
    i2c_transfer(1'b0, 8'h3C, 8'h11, 8'h96, 1);
    i2c_transfer(1'b0, 8'h3C, 8'h11, 8'h96, 2);
    i2c_transfer(1'b1, 8'hC3, 8'h69, 8'h00, 2);
    i2c_transfer(1'b1, 8'hC3, 8'h69, 8'h00, 0);
    drain();

    // address change in the middle of a read: read address follows the new value
    write_dev_addr(8'd254);
    push_req(i2cram_pkg::OP_READ, 8'h81, 8'h7E, 1'b0);
    bus_start();
    send_byte(1'b0);
    drain();
    write_dev_addr(8'd0);
    send_byte(1'b0);
    bus_start();
    send_byte(1'b0);
    recv_byte(8'hA5);
    bus_stop();
    i2c_transfer(1'b0, 8'h7F, 8'h80, 8'h5A, 3);
    drain();
    write_dev_addr(8'd254);
    i2c_transfer(1'b0, 8'h80, 8'h7F, 8'h01, 3);
    drain();

    junk_pct = 5;
    for (int ph = 0; ph < 3; ph++) begin
      write_dev_addr(ph == 0 ? 8'd0 : ph == 1 ? 8'd254 : 8'($urandom_range(0, 254)));
      if (ph == 2) calm = 1'b1;
      if ($urandom_range(0, 9) < 7) random_transfer();
      else garbled_transfer();
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/i2cram_pkg.sv
rtl/i2cram_core.sv
rtl/i2c_register_access_master_unit.sv
verif/i2c_register_access_master_unit_tb.sv
